// File: rtl/tcw_pkg.sv
package tcw_pkg;

	// Default geometry of the console.
	localparam int DEF_ROWS         = 32;
	localparam int DEF_VISIBLE_COLS = 42;
	localparam int DEF_ROW_STRIDE   = 64;
	localparam int DEF_TAB_STEP     = 4;

	// Control characters that the put operation interprets.
	localparam logic [7:0] CH_BS      = 8'd8;
	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] BLANK_CHAR = 8'h20;

	typedef enum logic [1:0] {
		OP_PUT   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] char_code;
		logic [4:0] read_row;
		logic [5:0] read_col;
	} req_item_t;

	typedef struct packed {
		logic [7:0] cell_data;
		logic [4:0] cursor_row;
		logic [5:0] cursor_col;
		logic       scrolled;
	} res_item_t;

	// How much work an incoming request needs.
	typedef enum logic [1:0] {
		KIND_SIMPLE,
		KIND_READ,
		KIND_CLEAR,
		KIND_SCROLL
	} kind_t;

	// Source of a result pushed into the output queue.
	typedef enum logic [1:0] {
		PUSH_NOW,
		PUSH_HELD,
		PUSH_READ
	} push_src_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FLUSH,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic      accept;
		logic      write_now;
		logic      write_pend;
		logic      sweep_full;
		logic      sweep_row;
		logic      sweep_en;
		logic      push;
		push_src_t push_src;
	} cmd_t;

	typedef struct packed {
		kind_t kind;
		logic  fifo_space;
		logic  sweep_last;
	} sts_t;

endpackage

// File: rtl/tcw_ctrl.sv
module tcw_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  tcw_pkg::sts_t sts,
	output logic          req_stall,
	output tcw_pkg::cmd_t cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		req_stall    = 1'b1;
		cmd          = '0;
		cmd.push_src = PUSH_NOW;
		unique case (state_q)
			ST_INIT: begin
				// The map is zeroed once after reset.
				cmd.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_stall = !sts.fifo_space;
				if (req_valid && sts.fifo_space) begin
					cmd.accept = 1'b1;
					unique case (sts.kind)
						KIND_SIMPLE: begin
							cmd.write_now = 1'b1;
							cmd.push      = 1'b1;
							cmd.push_src  = PUSH_NOW;
						end
						KIND_READ: begin
							state_d = ST_READ;
						end
						KIND_CLEAR: begin
							cmd.sweep_full = 1'b1;
							state_d        = ST_CLEAR;
						end
						KIND_SCROLL: begin
							cmd.sweep_row = 1'b1;
							state_d       = ST_SCROLL;
						end
					endcase
				end
			end
			ST_READ: begin
				cmd.push     = 1'b1;
				cmd.push_src = PUSH_READ;
				state_d      = ST_IDLE;
			end
			ST_SCROLL: begin
				cmd.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				// The character lands in the freshly cleared bottom row.
				cmd.write_pend = 1'b1;
				cmd.push       = 1'b1;
				cmd.push_src   = PUSH_HELD;
				state_d        = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.sweep_en = 1'b1;
				if (sts.sweep_last) begin
					cmd.push     = 1'b1;
					cmd.push_src = PUSH_HELD;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

`ifndef ASSERT_OFF
	a_flush_after_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> $past(state_q) == ST_SCROLL && $past(sts.sweep_last))
		else $error("flush entered without a finished row sweep");

	a_init_done: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q) == ST_INIT && state_q != ST_INIT |-> $past(sts.sweep_last))
		else $error("left the reset sweep early");

	a_read_answer: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.accept) && $past(sts.kind) == KIND_READ |->
			cmd.push && cmd.push_src == PUSH_READ)
		else $error("read result not pushed one cycle after accept");
`endif

endmodule

// File: rtl/tcw_datapath.sv
module tcw_datapath #(
	parameter int ROWS         = tcw_pkg::DEF_ROWS,
	parameter int VISIBLE_COLS = tcw_pkg::DEF_VISIBLE_COLS,
	parameter int ROW_STRIDE   = tcw_pkg::DEF_ROW_STRIDE,
	parameter int TAB_STEP     = tcw_pkg::DEF_TAB_STEP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tcw_pkg::req_item_t req_data,
	input  tcw_pkg::cmd_t      cmd,
	output tcw_pkg::sts_t      sts,
	output logic               res_valid,
	input  logic               res_stall,
	output tcw_pkg::res_item_t res_data
);
	import tcw_pkg::*;

	localparam int MAP    = ROWS * ROW_STRIDE;
	localparam int ADDR_W = $clog2(MAP);
	localparam int ROW_W  = $clog2(ROWS + 2);
	localparam int BASE_W = $clog2(ROWS);
	localparam int COL_W  = $clog2(VISIBLE_COLS + TAB_STEP);
	localparam logic [1:0] RES_DEPTH = 2'd2;

	// Cursor and the physical row that logical row 0 maps to.
	logic [ROW_W-1:0]  cur_row_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [BASE_W-1:0] base_q;

	logic [ROW_W-1:0]  nxt_row;
	logic [COL_W-1:0]  nxt_col;
	logic [BASE_W-1:0] base_n;
	logic [ROW_W-1:0]  r1;
	logic [COL_W-1:0]  c1;
	logic              wrapped;
	logic              parked_lf;
	logic              scroll;
	logic              wr_en;
	logic [ROW_W-1:0]  wr_row;
	logic [COL_W-1:0]  wr_col;
	logic [7:0]        wr_data;
	kind_t             kind;

	logic [31:0]       sum_w;
	logic [31:0]       phys_w;
	logic [ADDR_W-1:0] wr_addr;
	logic [31:0]       sum_r;
	logic [31:0]       phys_r;
	logic              rd_ok;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] row_base;

	logic [7:0]        mem_q [MAP];
	logic [7:0]        rd_data_q;
	logic              rd_ok_q;

	logic [ADDR_W-1:0] sweep_addr_q;
	logic [ADDR_W-1:0] sweep_end_q;

	logic              pend_en_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [7:0]        pend_data_q;

	res_item_t         res_comb;
	res_item_t         res_q;
	res_item_t         push_data;
	res_item_t         fifo_q [2];
	logic [1:0]        cnt_q;
	logic              pop;
	logic              idx;

	// Cursor movement and the cell write of one request.
	always_comb begin
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		base_n    = base_q;
		scroll    = 1'b0;
		wr_en     = 1'b0;
		wr_row    = cur_row_q;
		wr_col    = cur_col_q;
		wr_data   = BLANK_CHAR;
		kind      = KIND_SIMPLE;
		parked_lf = 1'b0;
		wrapped   = 32'(cur_col_q) >= 32'(VISIBLE_COLS);
		r1        = wrapped ? cur_row_q + ROW_W'(1) : cur_row_q;
		c1        = wrapped ? '0 : cur_col_q;
		unique case (req_data.op)
			OP_PUT: begin
				if (req_data.char_code == CH_BS) begin
					// Backspace at home does nothing.
					if (cur_row_q != '0 || cur_col_q != '0) begin
						if (cur_col_q == '0) begin
							nxt_row = cur_row_q - ROW_W'(1);
							nxt_col = COL_W'(VISIBLE_COLS - 1);
						end else begin
							nxt_col = cur_col_q - COL_W'(1);
						end
						wr_en  = (32'(nxt_row) < 32'(ROWS)) &&
							(32'(nxt_col) < 32'(ROW_STRIDE));
						wr_row = nxt_row;
						wr_col = nxt_col;
					end
				end else begin
					if (32'(r1) >= 32'(ROWS)) begin
						if (wrapped && req_data.char_code == CH_LF) begin
							parked_lf = 1'b1;
						end else begin
							r1     = ROW_W'(ROWS - 1);
							scroll = 1'b1;
							base_n = (32'(base_q) == 32'(ROWS - 1)) ? '0 :
								base_q + BASE_W'(1);
							kind   = KIND_SCROLL;
						end
					end
					if (parked_lf) begin
						nxt_row = ROW_W'(ROWS);
						nxt_col = '0;
					end else begin
						unique case (req_data.char_code)
							CH_LF: begin
								nxt_row = wrapped ? r1 : r1 + ROW_W'(1);
								nxt_col = '0;
							end
							CH_CR: begin
								nxt_row = r1;
								nxt_col = '0;
							end
							CH_TAB: begin
								nxt_row = r1;
								nxt_col = c1 + COL_W'(TAB_STEP);
							end
							default: begin
								nxt_row = r1;
								nxt_col = c1 + COL_W'(1);
								wr_en   = 32'(c1) < 32'(ROW_STRIDE);
								wr_row  = r1;
								wr_col  = c1;
								wr_data = req_data.char_code;
							end
						endcase
					end
				end
			end
			OP_READ: begin
				kind = KIND_READ;
			end
			OP_CLEAR: begin
				kind    = KIND_CLEAR;
				nxt_row = '0;
				nxt_col = '0;
			end
			OP_NOP: begin
				kind = KIND_SIMPLE;
			end
		endcase
	end

	// Logical rows rotate over the physical rows of the map.
	always_comb begin
		sum_w    = 32'(wr_row) + 32'(base_n);
		phys_w   = (sum_w >= 32'(ROWS)) ? sum_w - 32'(ROWS) : sum_w;
		wr_addr  = ADDR_W'(phys_w * 32'(ROW_STRIDE) + 32'(wr_col));
		rd_ok    = (32'(req_data.read_row) < 32'(ROWS)) &&
			(32'(req_data.read_col) < 32'(ROW_STRIDE));
		sum_r    = 32'(req_data.read_row) + 32'(base_q);
		phys_r   = (sum_r >= 32'(ROWS)) ? sum_r - 32'(ROWS) : sum_r;
		rd_addr  = rd_ok ? ADDR_W'(phys_r * 32'(ROW_STRIDE) + 32'(req_data.read_col)) : '0;
		row_base = ADDR_W'(32'(base_q) * 32'(ROW_STRIDE));
	end

	always_comb begin
		res_comb            = '0;
		res_comb.cursor_row = (32'(nxt_row) >= 32'(ROWS)) ? 5'(ROWS - 1) : 5'(nxt_row);
		res_comb.cursor_col = 6'(nxt_col);
		res_comb.scrolled   = scroll;
	end

	always_ff @(posedge clk) begin
		priority if (cmd.sweep_en) begin
			mem_q[sweep_addr_q] <= '0;
		end else if (cmd.write_now && wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end else if (cmd.write_pend && pend_en_q) begin
			mem_q[pend_addr_q] <= pend_data_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_row_q    <= ROW_W'(ROWS - 1);
			cur_col_q    <= '0;
			base_q       <= '0;
			sweep_addr_q <= '0;
			sweep_end_q  <= ADDR_W'(MAP - 1);
		end else begin
			if (cmd.accept) begin
				cur_row_q <= nxt_row;
				cur_col_q <= nxt_col;
				base_q    <= base_n;
			end
			priority if (cmd.sweep_full) begin
				sweep_addr_q <= '0;
				sweep_end_q  <= ADDR_W'(MAP - 1);
			end else if (cmd.sweep_row) begin
				// The old top row becomes the new bottom row.
				sweep_addr_q <= row_base;
				sweep_end_q  <= row_base + ADDR_W'(ROW_STRIDE - 1);
			end else if (cmd.sweep_en) begin
				sweep_addr_q <= sweep_addr_q + ADDR_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			res_q       <= res_comb;
			pend_en_q   <= wr_en;
			pend_addr_q <= wr_addr;
			pend_data_q <= wr_data;
			rd_ok_q     <= rd_ok;
		end
	end

	always_comb begin
		push_data = res_q;
		unique case (cmd.push_src)
			PUSH_NOW: begin
				push_data = res_comb;
			end
			PUSH_HELD: begin
				push_data = res_q;
			end
			PUSH_READ: begin
				push_data           = res_q;
				push_data.cell_data = rd_ok_q ? rd_data_q : '0;
			end
			default: begin
				push_data = res_q;
			end
		endcase
	end

	// Two-entry result queue; the head drives the output.
	assign pop = (cnt_q != 2'd0) && !res_stall;
	assign idx = 1'(cnt_q - 2'(pop));

	always_ff @(posedge clk) begin
		if (cmd.push && !idx) begin
			fifo_q[0] <= push_data;
		end else if (pop) begin
			fifo_q[0] <= fifo_q[1];
		end
		if (cmd.push && idx) begin
			fifo_q[1] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_q + 2'(cmd.push) - 2'(pop);
		end
	end

	assign res_valid = cnt_q != 2'd0;
	assign res_data  = fifo_q[0];

	assign sts.kind       = kind;
	assign sts.fifo_space = cnt_q != RES_DEPTH;
	assign sts.sweep_last = sweep_addr_q == sweep_end_q;

`ifndef ASSERT_OFF
	a_parked_col: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cur_row_q) == 32'(ROWS) |-> cur_col_q == '0)
		else $error("cursor parked below the map away from column zero");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push && !pop |-> cnt_q != RES_DEPTH)
		else $error("result pushed into a full queue");

	a_sweep_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep_en |-> 32'(sweep_addr_q) < 32'(MAP))
		else $error("clearing sweep left the map");
`endif

endmodule

// File: rtl/text_console_char_writer_core.sv
// Character-cell text console with a cursor and upward scrolling.
// The request channel (req_valid, req_stall, req_data) takes one operation per
// request: put a character, read one cell, clear the screen, or no operation.
// Every request gives exactly one result on the result channel (res_valid,
// res_stall, res_data): the cell byte for a read, the cursor and a scroll flag.
// An ordinary put or a no-op is pushed into the result queue as it is taken;
// such requests can follow each other in every cycle while the queue has room.
// A read waits in a read state before its result is pushed, because the map
// memory has a registered read port. A put that scrolls writes its character
// after a sweep: rows are remapped through a rotating base pointer, so only
// the new bottom row is zeroed, one cell a cycle through the single write port
// of the map memory. A clear zeroes the whole map, one cell a cycle.
// After reset the block zeroes the whole map with req_stall high; the cursor
// starts at column 0 of the last row.
// Results sit in a two-entry queue, so one more request is taken while a
// result waits; when the queue is full and the receiver stalls, req_stall
// rises and nothing is lost.
module text_console_char_writer_core #(
	parameter int ROWS         = tcw_pkg::DEF_ROWS,
	parameter int VISIBLE_COLS = tcw_pkg::DEF_VISIBLE_COLS,
	parameter int ROW_STRIDE   = tcw_pkg::DEF_ROW_STRIDE,
	parameter int TAB_STEP     = tcw_pkg::DEF_TAB_STEP
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  tcw_pkg::req_item_t req_data,
	output logic               res_valid,
	input  logic               res_stall,
	output tcw_pkg::res_item_t res_data
);
	import tcw_pkg::*;

	// The controller sequences sweeps and pushes; the datapath owns the map,
	// the cursor and the result queue.
	cmd_t cmd;
	sts_t sts;

	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.sts       (sts),
		.req_stall (req_stall),
		.cmd       (cmd)
	);

	tcw_datapath #(
		.ROWS         (ROWS),
		.VISIBLE_COLS (VISIBLE_COLS),
		.ROW_STRIDE   (ROW_STRIDE),
		.TAB_STEP     (TAB_STEP)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// File: verif/tb_text_console_char_writer_core.sv
module tb_text_console_char_writer_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tcw_pkg::*;

	// The console is built with the default geometry from the package.
	localparam int ROWS      = DEF_ROWS;
	localparam int VISIBLE   = DEF_VISIBLE_COLS;
	localparam int STRIDE    = DEF_ROW_STRIDE;
	localparam int TAB_STEP  = DEF_TAB_STEP;
	localparam int MAP_CELLS = ROWS * STRIDE;

	// Random requests per idling phase; four phases make about 1850 requests.
	localparam int REQUESTS_PER_PHASE = 463;

	// The slowest legal run of this stimulus includes the clearing pass after
	// reset, the odd full clear and the long receiver stalls. This cap sits far
	// above it.
	localparam int RUN_CYCLE_LIMIT = 1_000_000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_data  = '0;
	logic      res_valid;
	logic      res_stall = 1'b0;
	res_item_t res_data;

	text_console_char_writer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data (res_data)
	);

	// Requests waiting to be driven, and results the console still owes us.
	req_item_t request_backlog[$];
	res_item_t expected_results[$];

	// Our own copy of the console: the byte map and the cursor. The row is an
	// int so that it can stand one past the last row (the parked cursor).
	logic [7:0] screen [MAP_CELLS];
	int         cur_row;
	int         cur_col;

	// Percentages for sender idle cycles and receiver stall cycles.
	int idle_pct    = 0;
	int stall_pct   = 0;

	bit req_taken     = 1'b0;
	int queued_count  = 0;
	int error_count   = 0;
	int cycle_count   = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Console model
	// ------------------------------------------------------------------

	// Writes that land outside the stored map are dropped.
	function automatic void write_cell(int r, int c, logic [7:0] v);
		if (r < ROWS && c < STRIDE)
			screen[r * STRIDE + c] = v;
	endfunction

	// Handles one put character and returns 1 when the map scrolled.
	function automatic logic put_char(logic [7:0] ch);
		bit wrapped = 1'b0;
		bit scrolled = 1'b0;

		// Backspace never wraps forward or scrolls. At home it does nothing;
		// at column 0 (parked included) it goes to the end of the row above.
		if (ch == CH_BS) begin
			if (cur_row == 0 && cur_col == 0)
				return 1'b0;
			if (cur_col == 0) begin
				cur_row--;
				cur_col = VISIBLE;
			end
			cur_col--;
			write_cell(cur_row, cur_col, BLANK_CHAR);
			return 1'b0;
		end

		// A cursor at or past the visible width wraps before the byte is used.
		if (cur_col >= VISIBLE) begin
			cur_col = 0;
			cur_row++;
			wrapped = 1'b1;
		end

		if (cur_row >= ROWS) begin
			// A line feed right after a bottom wrap is swallowed: the cursor
			// stays parked and nothing scrolls yet.
			if (wrapped && ch == CH_LF) begin
				cur_row = ROWS;
				return 1'b0;
			end
			cur_row = ROWS - 1;
			for (int i = 0; i < MAP_CELLS - STRIDE; i++)
				screen[i] = screen[i + STRIDE];
			for (int i = MAP_CELLS - STRIDE; i < MAP_CELLS; i++)
				screen[i] = '0;
			scrolled = 1'b1;
		end

		case (ch)
			CH_LF: begin
				if (!wrapped)
					cur_row++;
				cur_col = 0;
			end
			CH_CR: cur_col = 0;
			CH_TAB: cur_col += TAB_STEP;
			default: begin
				write_cell(cur_row, cur_col, ch);
				cur_col++;
			end
		endcase
		return scrolled;
	endfunction

	// Applies one accepted request to the model and returns the result the
	// console has to give for it.
	function automatic res_item_t console_step(req_item_t r);
		res_item_t res;

		res = '0;
		case (op_t'(r.op))
			OP_PUT: res.scrolled = put_char(r.char_code);
			OP_READ: res.cell_data = screen[int'(r.read_row) * STRIDE + int'(r.read_col)];
			OP_CLEAR: begin
				foreach (screen[i])
					screen[i] = '0;
				cur_row = 0;
				cur_col = 0;
			end
			default: ;
		endcase
		// A parked cursor is reported on the last row.
		res.cursor_row = 5'((cur_row >= ROWS) ? ROWS - 1 : cur_row);
		res.cursor_col = 6'(cur_col);
		return res;
	endfunction

	// ------------------------------------------------------------------
	// Driver, monitor and watchdog
	// ------------------------------------------------------------------

	// Inputs change on the falling edge only. A request stays on the bus,
	// unchanged, until the rising edge that takes it; the idle decision does
	// not look at req_stall.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (request_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
				req_data  <= request_backlog.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// On the rising edge: check a result that leaves the console, then run the
	// model for a request that enters it. The order does not matter, since a
	// result never comes out in the cycle its request goes in.
	always @(posedge clk) begin : monitor
		res_item_t want;

		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					$error("result %h with no request outstanding", res_data);
					error_count++;
				end else begin
					want = expected_results.pop_front();
					if (res_data.cell_data !== want.cell_data) begin
						$error("cell_data: expected %0d, got %0d",
							want.cell_data, res_data.cell_data);
						error_count++;
					end
					if (res_data.cursor_row !== want.cursor_row) begin
						$error("cursor_row: expected %0d, got %0d",
							want.cursor_row, res_data.cursor_row);
						error_count++;
					end
					if (res_data.cursor_col !== want.cursor_col) begin
						$error("cursor_col: expected %0d, got %0d",
							want.cursor_col, res_data.cursor_col);
						error_count++;
					end
					if (res_data.scrolled !== want.scrolled) begin
						$error("scrolled: expected %0d, got %0d",
							want.scrolled, res_data.scrolled);
						error_count++;
					end
				end
			end
			if (req_valid && !req_stall)
				expected_results.push_back(console_step(req_data));
		end
		req_taken <= arst_n && req_valid && !req_stall;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_CYCLE_LIMIT) begin
			$display("text_console_char_writer_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// No-ops are not counted, because they leave the map and the cursor unchanged.
	task automatic queue_request(op_t op, logic [7:0] ch, logic [4:0] rr, logic [5:0] rc);
		req_item_t item;

		item.op        = op;
		item.char_code = ch;
		item.read_row  = rr;
		item.read_col  = rc;
		request_backlog.push_back(item);
		if (op != OP_NOP)
			queued_count++;
	endtask

	// Fields that an operation does not use are filled with noise.
	task automatic queue_put(logic [7:0] ch);
		queue_request(OP_PUT, ch, 5'($urandom_range(31)), 6'($urandom_range(63)));
	endtask

	task automatic queue_read(int r, int c);
		queue_request(OP_READ, 8'($urandom_range(255)), 5'(r), 6'(c));
	endtask

	// Mostly printable text, with some backspaces, tabs and arbitrary bytes.
	function automatic logic [7:0] text_byte();
		int pick = $urandom_range(99);

		if (pick < 78)
			return 8'($urandom_range(126, 32));
		if (pick < 84)
			return CH_BS;
		if (pick < 90)
			return CH_TAB;
		return 8'($urandom_range(255));
	endfunction

	// Random traffic shaped like terminal output: lines of text that often
	// fill the row exactly (so a wrap meets a line feed), read-backs around the
	// cursor, bursts of backspaces, line feeds and tabs, some noise, and the odd clear or no-op.
	task automatic queue_random_traffic(int count);
		int goal;
		int kind;
		int len;
		int pick;
		int row;
		bit plain;

		goal = queued_count + count;
		while (queued_count < goal) begin
			kind = $urandom_range(99);
			if (kind < 45) begin
				plain = ($urandom_range(3) == 0);
				len = plain ? VISIBLE : $urandom_range(50);
				repeat (len)
					queue_put(plain ? 8'($urandom_range(126, 32)) : text_byte());
				case ($urandom_range(3))
					0: queue_put(CH_LF);
					1: begin
						queue_put(CH_CR);
						queue_put(CH_LF);
					end
					2: queue_put(CH_CR);
					default: ;
				endcase
				if ($urandom_range(1))
					queue_read(ROWS - 1, $urandom_range(VISIBLE + 3));
			end else if (kind < 70) begin
				pick = $urandom_range(99);
				if (pick < 50)
					row = ROWS - 1;
				else if (pick < 65)
					row = ROWS - 2;
				else if (pick < 80)
					row = $urandom_range(3);
				else
					row = $urandom_range(ROWS - 1);
				queue_read(row, ($urandom_range(9) < 6) ? $urandom_range(VISIBLE + 3)
					: $urandom_range(STRIDE - 1));
			end else if (kind < 80) begin
				repeat ($urandom_range(6, 1))
					queue_put(CH_BS);
			end else if (kind < 88) begin
				repeat ($urandom_range(3, 1))
					queue_put(CH_LF);
			end else if (kind < 93) begin
				repeat ($urandom_range(12, 1))
					queue_put(CH_TAB);
			end else if (kind < 97) begin
				queue_request(op_t'($urandom_range(3)), 8'($urandom_range(255)),
					5'($urandom_range(31)), 6'($urandom_range(63)));
			end else if (kind < 99) begin
				queue_request(OP_CLEAR, 8'($urandom_range(255)), 5'($urandom_range(31)),
					6'($urandom_range(63)));
			end else begin
				queue_request(OP_NOP, 8'($urandom_range(255)), 5'($urandom_range(31)),
					6'($urandom_range(63)));
			end
		end
	endtask

	initial begin
		// Model state after reset: blank map, cursor at column 0 of the last row.
		foreach (screen[i])
			screen[i] = '0;
		cur_row = ROWS - 1;
		cur_col = 0;

		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// Directed requests. The map is blank after reset, so the corners read 0.
		queue_read(0, 0);
		queue_read(ROWS - 1, STRIDE - 1);
		queue_request(OP_NOP, 8'hff, 5'h1f, 6'h3f);
		queue_put("A");
		queue_put(8'hff);
		queue_put(8'h00);
		// Backspace blanks the cell it lands on.
		queue_put(CH_BS);
		queue_read(ROWS - 1, 2);
		queue_read(ROWS - 1, 0);
		queue_put(CH_TAB);
		queue_put(CH_CR);
		// Backspace at column 0 goes to the end of the row above.
		queue_put(CH_BS);
		queue_put(CH_LF);
		// A line feed on the last row parks the cursor below the map.
		queue_put(CH_LF);
		// Backspace while parked comes back to the end of the last row.
		queue_put(CH_BS);
		queue_put(CH_LF);
		// The next ordinary byte scrolls the map, so the text moves up a row.
		queue_put("B");
		queue_read(ROWS - 2, 0);
		queue_request(OP_CLEAR, 8'h00, 5'h00, 6'h00);
		// Backspace at home is ignored.
		queue_put(CH_BS);
		queue_read(ROWS - 2, 0);
		queue_put("C");
		queue_read(0, 0);

		// Four idling phases: none, sender idle, receiver stalls, a little of both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					idle_pct  = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct  = 69;
					stall_pct = 0;
				end
				2: begin
					idle_pct  = 0;
					stall_pct = 69;
				end
				default: begin
					idle_pct  = 6;
					stall_pct = 6;
				end
			endcase
			queue_random_traffic(REQUESTS_PER_PHASE);
			while (request_backlog.size() != 0)
				@(posedge clk);
		end

		// Let the last request go in and every result come out, then watch a
		// while longer for anything unexpected.
		while (req_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (4 * STRIDE) @(posedge clk);

		if (error_count == 0)
			$display("text_console_char_writer_core verification clean");
		else
			$display("text_console_char_writer_core verification failed");
		$finish;
	end

endmodule
